FILE: hw/rtl/cvdb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cvdb_pkg;

  localparam int unsigned Channels   = 4;
  localparam int unsigned ChIdxW     = $clog2(Channels);
  localparam int unsigned SampleInW  = 16;
  localparam int unsigned SampleBits = 12;
  localparam int unsigned AdcMax     = (1 << SampleBits) - 1;
  localparam int unsigned ThrW       = SampleBits + 1;
  localparam int unsigned RemapW     = 2 * Channels;
  localparam int unsigned CfgDataW   = ThrW;

  localparam int unsigned BarMax     = 28;
  localparam int unsigned BarW       = $clog2(BarMax + 2);
  localparam int unsigned FillW      = BarW;
  localparam int unsigned BarX0      = 82;
  localparam int unsigned BarPitch   = 12;
  localparam int unsigned XW         = 7;

  localparam logic [ThrW-1:0]   ThrReset   = ThrW'(41);
  localparam logic [RemapW-1:0] RemapReset = RemapW'(228);

  // bar length = floor((2*BarMax*level + AdcMax) / (2*AdcMax)), done as a
  // multiply by a scaled reciprocal of the divisor and a right shift
  localparam longint unsigned BarDiv   = 2 * AdcMax;
  localparam int unsigned     BarShift = 31;
  localparam longint unsigned BarRecip = ((64'd1 << BarShift) + BarDiv - 1) / BarDiv;
  localparam longint unsigned BarMul   = 2 * BarMax * BarRecip;
  localparam longint unsigned BarAdd   = AdcMax * BarRecip;
  localparam int unsigned     ProdW    = 40;

  // configuration register indexes
  localparam logic CfgThreshold = 1'b0;
  localparam logic CfgRemap     = 1'b1;

  typedef enum logic {
    ActSample  = 1'b0,
    ActRefresh = 1'b1
  } action_e;

  typedef enum logic {
    KindReport = 1'b0,
    KindRedraw = 1'b1
  } kind_e;

  typedef struct packed {
    kind_e                 kind;
    logic [ChIdxW-1:0]     index;
    logic [SampleBits-1:0] level;
    logic [XW-1:0]         bar_x;
    logic [FillW-1:0]      old_fill;
    logic [FillW-1:0]      new_fill;
  } result_t;

endpackage

`default_nettype wire

FILE: hw/rtl/cvdb_chan_unit.sv
`timescale 1ns / 1ps
`default_nettype none

module cvdb_chan_unit import cvdb_pkg::*; (
  input  action_e                action_i,
  input  logic [SampleInW-1:0]   sample_i,
  input  logic [SampleBits-1:0]  last_sent_i,
  input  logic                   sent_valid_i,
  input  logic [ThrW-1:0]        threshold_i,
  input  logic [SampleBits-1:0]  cur_level_i,
  input  logic [BarW-1:0]        old_bar_i,
  input  logic [ChIdxW-1:0]      pos_i,
  output logic                   hit_o,
  output logic [SampleBits-1:0]  level_o,
  output logic [BarW-1:0]        new_bar_o,
  output result_t                res_o
);

  logic [SampleBits-1:0] lvl;
  logic [SampleBits-1:0] delta;
  logic [ProdW-1:0]      prod;
  logic [BarW-1:0]       nb;
  logic                  report_hit;

  always_comb begin
    if (sample_i[SampleInW-1]) begin
      lvl = '0;
    end else if (|sample_i[SampleInW-2:SampleBits]) begin
      lvl = SampleBits'(AdcMax);
    end else begin
      lvl = sample_i[SampleBits-1:0];
    end
  end

  assign delta      = (lvl >= last_sent_i) ? (lvl - last_sent_i) : (last_sent_i - lvl);
  assign report_hit = !sent_valid_i || ({1'b0, delta} >= threshold_i);

  assign prod = ProdW'(cur_level_i) * ProdW'(BarMul) + ProdW'(BarAdd);
  assign nb   = prod[BarShift +: BarW];

  always_comb begin
    res_o       = '0;
    res_o.index = pos_i;
    if (action_i == ActSample) begin
      hit_o       = report_hit;
      res_o.kind  = KindReport;
      res_o.level = lvl;
    end else begin
      hit_o          = (nb != old_bar_i);
      res_o.kind     = KindRedraw;
      res_o.bar_x    = XW'(BarX0) + XW'(BarPitch) * XW'(pos_i);
      res_o.old_fill = FillW'(BarMax + 1) - old_bar_i;
      res_o.new_fill = FillW'(BarMax + 1) - nb;
    end
  end

  assign level_o   = lvl;
  assign new_bar_o = nb;

endmodule

`default_nettype wire

FILE: hw/rtl/cv_deadband_reporter_with_bars.sv
`timescale 1ns / 1ps
`default_nettype none

// Four-channel control-voltage change reporter with bar redraws. A sample
// item clamps each reading to 0..4095 and emits a report for every channel
// that was never sent or moved by at least the threshold; a refresh item
// emits a redraw for every display position whose bar length changed. One
// shared channel unit (clamp, abs-difference compare, bar multiply) handles
// one channel per cycle while out_ready_i does not stall a held result;
// after the last channel a flush state releases the final result and can
// already accept the next item. Results are delivered in channel order with
// last_o on the final one; an item may give no result. in_ready_o is low
// while the channels are worked on and in flush until the result can move.
module cv_deadband_reporter_with_bars import cvdb_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,

  input  logic                  cfg_we_i,
  input  logic                  cfg_index_i,
  input  logic [CfgDataW-1:0]   cfg_wdata_i,

  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  action_i,
  input  logic [SampleInW-1:0]  sample_0_i,
  input  logic [SampleInW-1:0]  sample_1_i,
  input  logic [SampleInW-1:0]  sample_2_i,
  input  logic [SampleInW-1:0]  sample_3_i,

  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  result_kind_o,
  output logic                  last_o,
  output logic [ChIdxW-1:0]     out_index_o,
  output logic [SampleBits-1:0] level_o,
  output logic [XW-1:0]         bar_x_o,
  output logic [FillW-1:0]      old_fill_o,
  output logic [FillW-1:0]      new_fill_o
);

  typedef enum logic [1:0] {
    StIdle,
    StRun,
    StFlush
  } state_e;

  state_e                state_q;
  logic [ChIdxW-1:0]     ch_q;
  action_e               action_q;
  logic [SampleInW-1:0]  sample_q    [Channels];
  logic [ThrW-1:0]       thr_q;
  logic [RemapW-1:0]     remap_q;

  logic [SampleBits-1:0] last_sent_q [Channels];
  logic                  sent_valid_q[Channels];
  logic [SampleBits-1:0] cur_level_q [Channels];
  logic [BarW-1:0]       bar_len_q   [Channels];

  result_t               pend_q;
  logic                  pend_valid_q;
  result_t               out_q;
  logic                  out_last_q;
  logic                  out_valid_q;

  logic [ChIdxW-1:0]     pos;
  logic                  hit;
  logic [SampleBits-1:0] unit_level;
  logic [BarW-1:0]       unit_bar;
  result_t               unit_res;
  logic                  out_free;
  logic                  step;
  logic                  flush_ok;
  logic                  in_xfer;
  logic                  out_load;

  assign pos = remap_q[ChIdxW*ch_q +: ChIdxW];

  cvdb_chan_unit u_unit (
    .action_i    (action_q),
    .sample_i    (sample_q[ch_q]),
    .last_sent_i (last_sent_q[ch_q]),
    .sent_valid_i(sent_valid_q[ch_q]),
    .threshold_i (thr_q),
    .cur_level_i (cur_level_q[ch_q]),
    .old_bar_i   (bar_len_q[pos]),
    .pos_i       (pos),
    .hit_o       (hit),
    .level_o     (unit_level),
    .new_bar_o   (unit_bar),
    .res_o       (unit_res)
  );

  assign out_free = !out_valid_q || out_ready_i;
  // a new result can only be taken when the pending one has somewhere to go
  assign step     = !(hit && pend_valid_q) || out_free;
  assign flush_ok = !pend_valid_q || out_free;

  // the held result moves to the output register
  assign out_load = ((state_q == StRun) && step && hit && pend_valid_q) ||
                    ((state_q == StFlush) && flush_ok && pend_valid_q);

  always_comb begin
    unique case (state_q)
      StIdle:  in_ready_o = 1'b1;
      StFlush: in_ready_o = flush_ok;
      default: in_ready_o = 1'b0;
    endcase
  end

  assign in_xfer = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      ch_q         <= '0;
      action_q     <= ActSample;
      thr_q        <= ThrReset;
      remap_q      <= RemapReset;
      pend_q       <= '0;
      pend_valid_q <= 1'b0;
      out_q        <= '0;
      out_last_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      for (int i = 0; i < Channels; i++) begin
        sample_q[i]     <= '0;
        last_sent_q[i]  <= '0;
        sent_valid_q[i] <= 1'b0;
        cur_level_q[i]  <= '0;
        bar_len_q[i]    <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CfgThreshold: thr_q   <= cfg_wdata_i[ThrW-1:0];
          CfgRemap:     remap_q <= cfg_wdata_i[RemapW-1:0];
          default:      ;
        endcase
      end

      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      if (in_xfer) begin
        action_q    <= action_e'(action_i);
        sample_q[0] <= sample_0_i;
        sample_q[1] <= sample_1_i;
        sample_q[2] <= sample_2_i;
        sample_q[3] <= sample_3_i;
        ch_q        <= '0;
      end

      unique case (state_q)
        StIdle: begin
          if (in_xfer) begin
            state_q <= StRun;
          end
        end
        StRun: begin
          if (step) begin
            if (action_q == ActSample) begin
              cur_level_q[ch_q] <= unit_level;
              if (hit) begin
                last_sent_q[ch_q]  <= unit_level;
                sent_valid_q[ch_q] <= 1'b1;
              end
            end else if (hit) begin
              bar_len_q[pos] <= unit_bar;
            end
            if (hit) begin
              // push the held result out, it is not the final one
              if (pend_valid_q) begin
                out_q      <= pend_q;
                out_last_q <= 1'b0;
              end
              pend_q       <= unit_res;
              pend_valid_q <= 1'b1;
            end
            if (ch_q == ChIdxW'(Channels - 1)) begin
              state_q <= StFlush;
            end
            ch_q <= ch_q + 1'b1;
          end
        end
        StFlush: begin
          if (flush_ok) begin
            if (pend_valid_q) begin
              out_q        <= pend_q;
              out_last_q   <= 1'b1;
              pend_valid_q <= 1'b0;
            end
            state_q <= in_xfer ? StRun : StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign out_valid_o   = out_valid_q;
  assign result_kind_o = out_q.kind;
  assign last_o        = out_last_q;
  assign out_index_o   = out_q.index;
  assign level_o       = out_q.level;
  assign bar_x_o       = out_q.bar_x;
  assign old_fill_o    = out_q.old_fill;
  assign new_fill_o    = out_q.new_fill;

endmodule

`default_nettype wire
